/* rtl/ebms_pkg.sv */
package ebms_pkg;

   // Geometry of the reference store
   localparam int ENTRIES = 64;
   localparam int DIM     = 128;

   localparam int SLOT_IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int DIM_IDX_W  = (DIM > 1) ? $clog2(DIM) : 1;
   localparam int REF_DEPTH  = ENTRIES * DIM;
   localparam int REF_ADDR_W = (REF_DEPTH > 1) ? $clog2(REF_DEPTH) : 1;

   // Field widths
   localparam int CMD_W         = 2;
   localparam int SLOT_FIELD_W  = 6;
   localparam int INDEX_FIELD_W = 7;
   localparam int ELEM_W        = 16;
   localparam int STATUS_W      = 2;
   localparam int SCORE_W       = 39;
   localparam int PROD_W        = 2 * ELEM_W;

   // Accumulator holds DIM exact Q2.30 products without overflow
   localparam int ACC_RAW_W = PROD_W + DIM_IDX_W + 1;
   localparam int ACC_W     = (ACC_RAW_W > SCORE_W + 1) ? ACC_RAW_W : SCORE_W + 1;

   localparam logic signed [SCORE_W-1:0] SCORE_MAX = {1'b0, {(SCORE_W-1){1'b1}}};
   localparam logic signed [SCORE_W-1:0] SCORE_MIN = {1'b1, {(SCORE_W-1){1'b0}}};
   localparam logic signed [SCORE_W-1:0] MINUS_ONE = SCORE_W'(-64'sd1073741824);

   typedef enum logic [CMD_W-1:0] {
      CMD_WRITE = 2'd0,
      CMD_QUERY = 2'd1,
      CMD_CLEAR = 2'd2
   } ebms_cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_MATCH    = 2'd0,
      STATUS_NO_MATCH = 2'd1,
      STATUS_EMPTY    = 2'd2
   } ebms_status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_DONE
   } ebms_state_type;

   typedef struct packed {
      logic                  ref_we;
      logic                  query_we;
      logic                  set_valid;
      logic                  clear_all;
      logic                  search_start;
      logic                  rd_en;
      logic                  rd_first;
      logic                  rd_final;
      logic                  rsp_load;
      logic [SLOT_IDX_W-1:0] rd_slot;
      logic [DIM_IDX_W-1:0]  rd_index;
   } ebms_ctl_cmd_type;

   typedef struct packed {
      logic slot_valid;
      logic pipe_busy;
   } ebms_dp_status_type;

endpackage

/* rtl/ebms_channels.sv */
interface ebms_req_if;
   logic                                      valid;
   logic                                      ready;
   logic [ebms_pkg::CMD_W-1:0]                command;
   logic [ebms_pkg::SLOT_FIELD_W-1:0]         slot;
   logic [ebms_pkg::INDEX_FIELD_W-1:0]        element_index;
   logic signed [ebms_pkg::ELEM_W-1:0]        element;
   logic                                      last;

   modport source (output valid, command, slot, element_index, element, last, input ready);
   modport sink   (input valid, command, slot, element_index, element, last, output ready);
endinterface

interface ebms_rsp_if;
   logic                                      valid;
   logic                                      ready;
   logic [ebms_pkg::STATUS_W-1:0]             status;
   logic [ebms_pkg::SLOT_FIELD_W-1:0]         best_slot;
   logic signed [ebms_pkg::SCORE_W-1:0]       top_score;

   modport source (output valid, status, best_slot, top_score, input ready);
   modport sink   (input valid, status, best_slot, top_score, output ready);
endinterface

interface ebms_csr_if;
   logic                                      valid;
   logic                                      ready;
   logic signed [ebms_pkg::SCORE_W-1:0]       match_threshold;

   modport source (output valid, match_threshold, input ready);
   modport sink   (input valid, match_threshold, output ready);
endinterface

/* rtl/ebms_controller.sv */
module ebms_controller (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  logic [ebms_pkg::CMD_W-1:0]              req_command,
   input  logic [ebms_pkg::SLOT_FIELD_W-1:0]       req_slot,
   input  logic [ebms_pkg::INDEX_FIELD_W-1:0]      req_element_index,
   input  logic                                    req_last,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   input  ebms_pkg::ebms_dp_status_type            status,
   output ebms_pkg::ebms_ctl_cmd_type              cmd
);

   ebms_pkg::ebms_state_type              state_ff, state_in;
   logic [ebms_pkg::SLOT_IDX_W-1:0]       slot_ff, slot_in;
   logic [ebms_pkg::DIM_IDX_W-1:0]        index_ff, index_in;
   logic                                  rsp_valid_ff, rsp_valid_in;
   logic                                  slot_ok, index_ok, slot_end, index_end;

   assign slot_ok   = 32'(req_slot) < ebms_pkg::ENTRIES;
   assign index_ok  = 32'(req_element_index) < ebms_pkg::DIM;
   assign slot_end  = slot_ff == ebms_pkg::SLOT_IDX_W'(ebms_pkg::ENTRIES - 1);
   assign index_end = index_ff == ebms_pkg::DIM_IDX_W'(ebms_pkg::DIM - 1);
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ebms_pkg::ST_IDLE;
         slot_ff      <= '0;
         index_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         slot_ff      <= slot_in;
         index_ff     <= index_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      slot_in      = slot_ff;
      index_in     = index_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      req_ready    = 1'b0;
      cmd          = '0;
      cmd.rd_slot  = slot_ff;
      cmd.rd_index = index_ff;
      case (state_ff)
         ebms_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               case (req_command)
                  ebms_pkg::CMD_WRITE: begin
                     cmd.ref_we    = slot_ok & index_ok;
                     cmd.set_valid = slot_ok & req_last;
                  end
                  ebms_pkg::CMD_QUERY: begin
                     cmd.query_we = index_ok;
                     if (req_last) begin
                        cmd.search_start = 1'b1;
                        slot_in          = '0;
                        index_in         = '0;
                        state_in         = ebms_pkg::ST_SCAN;
                     end
                  end
                  ebms_pkg::CMD_CLEAR: begin
                     cmd.clear_all = 1'b1;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ebms_pkg::ST_SCAN: begin
            // skip an empty slot, stream DIM reads for a valid one
            if (status.slot_valid) begin
               cmd.rd_en    = 1'b1;
               cmd.rd_first = index_ff == '0;
               cmd.rd_final = index_end;
            end
            if (!status.slot_valid || index_end) begin
               index_in = '0;
               if (slot_end) begin
                  state_in = ebms_pkg::ST_DRAIN;
               end else begin
                  slot_in = slot_ff + 1'b1;
               end
            end else begin
               index_in = index_ff + 1'b1;
            end
         end
         ebms_pkg::ST_DRAIN: begin
            if (!status.pipe_busy) begin
               state_in = ebms_pkg::ST_DONE;
            end
         end
         ebms_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.rsp_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ebms_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ebms_pkg::ST_IDLE;
         end
      endcase
   end

`ifndef ASSERT_OFF
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> (!rsp_valid_ff || rsp_ready))
      else $error("result loaded over a pending beat");

   a_start_scan: assert property (@(posedge clock) disable iff (reset)
      cmd.search_start |=> (state_ff == ebms_pkg::ST_SCAN && slot_ff == '0))
      else $error("search did not start at the first slot");

   a_read_no_write: assert property (@(posedge clock) disable iff (reset)
      cmd.rd_en |-> (!cmd.ref_we && !cmd.query_we && !req_ready))
      else $error("scan read overlaps a store write");
`endif

endmodule

/* rtl/ebms_datapath.sv */
module ebms_datapath (
   input  logic                                    clock,
   input  logic                                    reset,
   input  ebms_pkg::ebms_ctl_cmd_type              cmd,
   output ebms_pkg::ebms_dp_status_type            status,
   input  logic [ebms_pkg::SLOT_FIELD_W-1:0]       req_slot,
   input  logic [ebms_pkg::INDEX_FIELD_W-1:0]      req_element_index,
   input  logic signed [ebms_pkg::ELEM_W-1:0]      req_element,
   input  logic                                    csr_we,
   input  logic signed [ebms_pkg::SCORE_W-1:0]     csr_data,
   output logic [ebms_pkg::STATUS_W-1:0]           rsp_status,
   output logic [ebms_pkg::SLOT_FIELD_W-1:0]       rsp_best_slot,
   output logic signed [ebms_pkg::SCORE_W-1:0]     rsp_top_score
);

   logic signed [ebms_pkg::ELEM_W-1:0]   ref_mem [ebms_pkg::REF_DEPTH];
   logic signed [ebms_pkg::ELEM_W-1:0]   query_mem [ebms_pkg::DIM];
   logic [ebms_pkg::ENTRIES-1:0]         slot_valid_ff;

   logic [ebms_pkg::REF_ADDR_W-1:0]      wr_addr, rd_addr;
   logic [ebms_pkg::SLOT_IDX_W-1:0]      wr_slot;
   logic [ebms_pkg::DIM_IDX_W-1:0]       wr_index;

   logic signed [ebms_pkg::SCORE_W-1:0]  threshold_ff;

   // stage 1: read data
   logic                                 v1_ff, first1_ff, final1_ff;
   logic [ebms_pkg::SLOT_IDX_W-1:0]      slot1_ff;
   logic signed [ebms_pkg::ELEM_W-1:0]   ref_rd_ff, query_rd_ff;
   // stage 2: product
   logic                                 v2_ff, first2_ff, final2_ff;
   logic [ebms_pkg::SLOT_IDX_W-1:0]      slot2_ff;
   logic signed [ebms_pkg::PROD_W-1:0]   prod_ff, prod_in;
   // stage 3: accumulate and saturate
   logic signed [ebms_pkg::ACC_W-1:0]    acc_ff, acc_in;
   logic                                 v3_ff;
   logic [ebms_pkg::SLOT_IDX_W-1:0]      slot3_ff;
   logic signed [ebms_pkg::SCORE_W-1:0]  score_ff, score_in;
   // stage 4: running best
   logic                                 any_ff, chosen_ff;
   logic signed [ebms_pkg::SCORE_W-1:0]  best_ff;
   logic [ebms_pkg::SLOT_IDX_W-1:0]      best_slot_ff;

   logic [ebms_pkg::STATUS_W-1:0]        status_in;
   logic [ebms_pkg::STATUS_W-1:0]        rsp_status_ff;
   logic [ebms_pkg::SLOT_FIELD_W-1:0]    rsp_slot_ff;
   logic signed [ebms_pkg::SCORE_W-1:0]  rsp_score_ff;

   assign wr_slot  = ebms_pkg::SLOT_IDX_W'(32'(req_slot));
   assign wr_index = ebms_pkg::DIM_IDX_W'(32'(req_element_index));
   assign wr_addr  = ebms_pkg::REF_ADDR_W'(32'(wr_slot) * ebms_pkg::DIM + 32'(wr_index));
   assign rd_addr  = ebms_pkg::REF_ADDR_W'(32'(cmd.rd_slot) * ebms_pkg::DIM
                                           + 32'(cmd.rd_index));

   assign status.slot_valid = slot_valid_ff[cmd.rd_slot];
   assign status.pipe_busy  = v1_ff | v2_ff | v3_ff;

   always_ff @(posedge clock) begin
      if (cmd.ref_we) begin
         ref_mem[wr_addr] <= req_element;
      end
      if (cmd.rd_en) begin
         ref_rd_ff <= ref_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.query_we) begin
         query_mem[wr_index] <= req_element;
      end
      if (cmd.rd_en) begin
         query_rd_ff <= query_mem[cmd.rd_index];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_valid_ff <= '0;
         threshold_ff  <= '0;
         v1_ff         <= 1'b0;
         v2_ff         <= 1'b0;
         v3_ff         <= 1'b0;
      end else begin
         if (cmd.clear_all) begin
            slot_valid_ff <= '0;
         end else if (cmd.set_valid) begin
            slot_valid_ff[wr_slot] <= 1'b1;
         end
         if (csr_we) begin
            threshold_ff <= csr_data;
         end
         v1_ff <= cmd.rd_en;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff & final2_ff;
      end
   end

   assign prod_in = query_rd_ff * ref_rd_ff;
   assign acc_in  = first2_ff ? ebms_pkg::ACC_W'(prod_ff)
                              : acc_ff + ebms_pkg::ACC_W'(prod_ff);

   always_comb begin
      if (acc_in > ebms_pkg::ACC_W'(ebms_pkg::SCORE_MAX)) begin
         score_in = ebms_pkg::SCORE_MAX;
      end else if (acc_in < ebms_pkg::ACC_W'(ebms_pkg::SCORE_MIN)) begin
         score_in = ebms_pkg::SCORE_MIN;
      end else begin
         score_in = ebms_pkg::SCORE_W'(acc_in);
      end
   end

   always_ff @(posedge clock) begin
      first1_ff <= cmd.rd_first;
      final1_ff <= cmd.rd_final;
      slot1_ff  <= cmd.rd_slot;
      first2_ff <= first1_ff;
      final2_ff <= final1_ff;
      slot2_ff  <= slot1_ff;
      prod_ff   <= prod_in;
      if (v2_ff) begin
         acc_ff <= acc_in;
      end
      if (v2_ff && final2_ff) begin
         score_ff <= score_in;
         slot3_ff <= slot2_ff;
      end
   end

   // running best: first strictly greater score wins, starting from -1.0
   always_ff @(posedge clock) begin
      if (cmd.search_start) begin
         any_ff       <= 1'b0;
         chosen_ff    <= 1'b0;
         best_ff      <= ebms_pkg::MINUS_ONE;
         best_slot_ff <= '0;
      end else if (v3_ff) begin
         any_ff <= 1'b1;
         if (score_ff > best_ff) begin
            chosen_ff    <= 1'b1;
            best_ff      <= score_ff;
            best_slot_ff <= slot3_ff;
         end
      end
   end

   always_comb begin
      if (!any_ff) begin
         status_in = ebms_pkg::STATUS_EMPTY;
      end else if (chosen_ff && best_ff >= threshold_ff) begin
         status_in = ebms_pkg::STATUS_MATCH;
      end else begin
         status_in = ebms_pkg::STATUS_NO_MATCH;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_status_ff <= status_in;
         rsp_slot_ff   <= ebms_pkg::SLOT_FIELD_W'(32'(best_slot_ff));
         rsp_score_ff  <= best_ff;
      end
   end

   assign rsp_status     = rsp_status_ff;
   assign rsp_best_slot  = rsp_slot_ff;
   assign rsp_top_score  = rsp_score_ff;

`ifndef ASSERT_OFF
   a_final_follows: assert property (@(posedge clock) disable iff (reset)
      v3_ff |-> $past(v1_ff, 2))
      else $error("score produced without a read two cycles earlier");
`endif

endmodule

/* rtl/embedding_best_match_search_unit.sv */
// Embedding best-match search over a store of reference vectors.
// req_bus carries one element beat per item: write a reference element,
// load a query element, or clear all slots. A write beat with last marks
// its slot valid. A query beat with last starts the search: req_bus.ready
// stays low while every slot is visited in order. An invalid slot is
// skipped; a valid slot is streamed through a read / multiply /
// accumulate pipeline, one read of the reference and query RAMs per
// cycle, and the pipeline drains before the result is registered.
// rsp_bus returns one beat per search: status, best slot and best score.
// The result sits in an output register, so element beats are accepted
// while it waits; a later search holds its result until the receiver
// takes the pending one.
// csr_bus writes the match threshold and is always ready.
// Reset clears the slot valid bits, the threshold and all control state;
// the stored elements are left as they are.
module embedding_best_match_search_unit (
   input  logic        clock,
   input  logic        reset,
   ebms_req_if.sink    req_bus,
   ebms_rsp_if.source  rsp_bus,
   ebms_csr_if.sink    csr_bus
);

   ebms_pkg::ebms_ctl_cmd_type    cmd;
   ebms_pkg::ebms_dp_status_type  status;

   // threshold register accepts a beat in every cycle
   assign csr_bus.ready = 1'b1;

   ebms_controller u_ctl (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_bus.valid),
      .req_ready         (req_bus.ready),
      .req_command       (req_bus.command),
      .req_slot          (req_bus.slot),
      .req_element_index (req_bus.element_index),
      .req_last          (req_bus.last),
      .rsp_valid         (rsp_bus.valid),
      .rsp_ready         (rsp_bus.ready),
      .status            (status),
      .cmd               (cmd)
   );

   ebms_datapath u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_slot          (req_bus.slot),
      .req_element_index (req_bus.element_index),
      .req_element       (req_bus.element),
      .csr_we            (csr_bus.valid),
      .csr_data          (csr_bus.match_threshold),
      .rsp_status        (rsp_bus.status),
      .rsp_best_slot     (rsp_bus.best_slot),
      .rsp_top_score     (rsp_bus.top_score)
   );

endmodule
